/* rtl/mvma_pkg.sv */
package mvma_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DIM_W   = 5;
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 8;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 4;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_X = 2'd1,
        MODE_LOAD_B = 2'd2,
        MODE_RUN    = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM       = 2'd0,
        CFG_TRANSPOSE = 2'd1,
        CFG_SCALE     = 2'd2
    } t_cfg_idx;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_SUM,
        ST_SAT,
        ST_EMIT
    } t_state;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        t_mode              mode;
        logic [INDEX_W-1:0] index;
        logic [VAL_W-1:0]   value;
    } t_req;

endpackage

/* rtl/mvma_front.sv */
// Accepts input requests, drops out-of-range loads and queues the rest.
module mvma_front #(
    parameter int MAX_DIM = mvma_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [mvma_pkg::MODE_W-1:0]   i_mode,
    input  logic [mvma_pkg::INDEX_W-1:0]  i_index,
    input  logic [mvma_pkg::VAL_W-1:0]    i_value,
    output logic                          o_req_valid,
    output mvma_pkg::t_req                o_req,
    input  logic                          i_req_take
);
    import mvma_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int A_SIZE = MAX_DIM * MAX_DIM;

    t_req              r_q [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [PTR_W:0]    r_cnt;
    logic              w_keep;
    logic              w_acc;
    t_req              w_req;

    // Classify: out-of-range loads produce nothing and are dropped here.
    always_comb begin
        w_req.mode  = t_mode'(i_mode);
        w_req.index = i_index;
        w_req.value = i_value;
        case (t_mode'(i_mode))
            MODE_LOAD_A: w_keep = (32'(i_index) < A_SIZE);
            MODE_LOAD_X,
            MODE_LOAD_B: w_keep = (32'(i_index) < MAX_DIM);
            MODE_RUN:    w_keep = 1'b1;
            default:     w_keep = 1'b0;
        endcase
    end

    assign o_full      = (r_cnt == (PTR_W+1)'(DEPTH));
    assign w_acc       = i_push && !o_full;
    assign o_req_valid = (r_cnt != '0);
    assign o_req       = r_q[r_rd];

    // Hold queue entries.
    always_ff @(posedge i_clk) begin
        if (w_acc && w_keep) begin
            r_q[r_wr] <= w_req;
        end
    end

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_acc && w_keep) r_wr <= r_wr + 1'b1;
            if (i_req_take)      r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(w_acc && w_keep) - (PTR_W+1)'(i_req_take);
        end
    end

endmodule

/* rtl/mvma_back.sv */
// Executes loads into the stores and runs the multiply-accumulate sweep.
module mvma_back #(
    parameter int MAX_DIM   = mvma_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mvma_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mvma_pkg::DIM_W-1:0]   i_dim,
    input  logic                         i_transpose,
    input  logic [mvma_pkg::VAL_W-1:0]   i_scale,
    input  logic                         i_req_valid,
    input  mvma_pkg::t_req               i_req,
    output logic                         o_req_take,
    output logic                         o_out_valid,
    input  logic                         i_out_take,
    output logic [mvma_pkg::POS_W-1:0]   o_position,
    output logic [mvma_pkg::VAL_W-1:0]   o_result,
    output logic                         o_last,
    output logic                         o_saturated,
    output logic                         o_busy
);
    import mvma_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int CW    = $clog2(MAX_DIM + 1);
    localparam int ACC_W = 64 + CW;
    localparam int SH    = 2 * FRAC_BITS;
    localparam int PRD_W = ACC_W + 32;

    logic [VAL_W-1:0] r_amem [MAX_DIM*MAX_DIM];
    logic [VAL_W-1:0] r_xmem [MAX_DIM];
    logic [VAL_W-1:0] r_bmem [MAX_DIM];
    logic [MAX_DIM-1:0] r_bval;

    t_state r_st, n_st;
    logic [CW-1:0]  r_n;
    logic [IW-1:0]  r_i, r_j;
    logic [AW-1:0]  r_addr_rd;
    logic [IW-1:0]  r_xaddr_rd;
    logic           r_rdv;
    logic           r_dv;
    logic signed [VAL_W-1:0] r_ad, r_xd;
    logic signed [63:0]      r_prod;
    logic           r_pv;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [PRD_W-1:0] r_plo, r_phi, r_full;
    logic signed [VAL_W-1:0] r_bold;
    logic [VAL_W-1:0]        r_fresh;
    logic                    r_fsat;
    logic                    r_ov;
    logic [IW-1:0]           r_opos;
    logic                    r_olast;
    logic [VAL_W-1:0]        r_ores;
    logic                    r_fsat_o;

    logic [CW-1:0] w_n;
    logic [AW-1:0] w_addr;
    logic          w_jl, w_il;
    logic          w_emit;
    logic signed [PRD_W-1:0] w_sum;
    logic signed [PRD_W-1:0] w_sh;
    logic signed [PRD_W:0]   w_tot;

    function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] i,
                                               input logic [IW-1:0] j,
                                               input logic [CW-1:0] n,
                                               input logic          tr);
        logic [AW-1:0] row, col;
        row = tr ? AW'(j) : AW'(i);
        col = tr ? AW'(i) : AW'(j);
        return AW'(row * AW'(n) + col);
    endfunction

    // Clamp dim to 1..MAX_DIM.
    always_comb begin
        if (i_dim == '0)                      w_n = CW'(1);
        else if (32'(i_dim) > MAX_DIM)        w_n = CW'(MAX_DIM);
        else                                  w_n = CW'(i_dim);
    end

    assign w_jl = (32'(r_j) + 1 == 32'(r_n));
    assign w_il = (32'(r_i) + 1 == 32'(r_n));
    assign w_addr = mat_addr(r_i, r_j, r_n, i_transpose);
    assign w_emit = (r_st == ST_EMIT) && (!r_ov || i_out_take);

    assign o_req_take  = i_req_valid && (r_st == ST_IDLE);
    assign o_busy      = (r_st != ST_IDLE) || r_ov;
    assign o_out_valid = r_ov;
    assign o_position  = POS_W'(r_opos);
    assign o_result    = r_ores;
    assign o_last      = r_olast;
    assign o_saturated = r_fsat_o;

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:     if (o_req_take && i_req.mode == MODE_RUN) n_st = ST_MAC;
            ST_MAC:      if (w_jl) n_st = ST_DRAIN;
            ST_DRAIN:    if (!r_rdv && !r_dv && !r_pv) n_st = ST_SCALE_LO;
            ST_SCALE_LO: n_st = ST_SCALE_HI;
            ST_SCALE_HI: n_st = ST_SUM;
            ST_SUM:      n_st = ST_SAT;
            ST_SAT:      n_st = ST_EMIT;
            ST_EMIT:     if (w_emit) n_st = w_il ? ST_IDLE : ST_MAC;
            default:     n_st = ST_IDLE;
        endcase
    end

    // Split scale multiply: low 32 bits and upper bits of the accumulator, summed exactly.
    assign w_sum = r_plo + (r_phi <<< 32);
    assign w_sh  = r_full >>> SH;

    // Stores.
    always_ff @(posedge i_clk) begin
        if (o_req_take && i_req.mode == MODE_LOAD_A) r_amem[AW'(i_req.index)] <= i_req.value;
        if (o_req_take && i_req.mode == MODE_LOAD_X) r_xmem[IW'(i_req.index)] <= i_req.value;
        if (o_req_take && i_req.mode == MODE_LOAD_B) r_bmem[IW'(i_req.index)] <= i_req.value;
        else if (w_emit) r_bmem[r_i] <= r_fresh;
        r_ad <= r_amem[r_addr_rd];
        r_xd <= r_xmem[r_xaddr_rd];
    end

    // Datapath: read, multiply, old b fetch, scale, sum.
    always_ff @(posedge i_clk) begin
        r_addr_rd  <= w_addr;
        r_xaddr_rd <= r_j;
        r_prod     <= r_ad * r_xd;
        r_bold     <= r_bval[r_i] ? $signed(r_bmem[r_i]) : '0;
        case (r_st)
            ST_SCALE_LO: r_plo <= $signed({1'b0, r_acc[31:0]}) * $signed(i_scale);
            ST_SCALE_HI: r_phi <= $signed(r_acc[ACC_W-1:32]) * $signed(i_scale);
            ST_SUM:      r_full <= w_sum;
            default: ;
        endcase
    end

    // Saturating add of the old b element.
    assign w_tot = PRD_W'(w_sh) + r_bold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_rdv  <= 1'b0;
            r_dv   <= 1'b0;
            r_pv   <= 1'b0;
            r_ov   <= 1'b0;
            r_bval <= '0;
            r_i    <= '0;
            r_j    <= '0;
            r_n    <= CW'(1);
        end else begin
            r_st  <= n_st;
            r_rdv <= (r_st == ST_MAC);
            r_dv  <= r_rdv;
            r_pv  <= r_dv;
            if (o_req_take && i_req.mode == MODE_LOAD_B) r_bval[IW'(i_req.index)] <= 1'b1;
            if (r_st == ST_IDLE) begin
                r_n <= w_n;
                r_i <= '0;
                r_j <= '0;
            end
            if (r_st == ST_MAC) r_j <= w_jl ? '0 : r_j + 1'b1;
            if (w_emit) r_ov <= 1'b1;
            else if (r_ov && i_out_take) r_ov <= 1'b0;
            if (w_emit) begin
                r_opos   <= r_i;
                r_olast  <= w_il;
                r_ores   <= r_fresh;
                r_fsat_o <= r_fsat;
                r_bval[r_i] <= 1'b1;
                r_i <= w_il ? '0 : r_i + 1'b1;
            end
        end
    end

    // Accumulator and result registers.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE || (r_st == ST_EMIT)) r_acc <= '0;
        else if (r_pv) r_acc <= r_acc + ACC_W'(r_prod);
        if (r_st == ST_SAT) begin
            if (w_tot > $signed({{(PRD_W-31){1'b0}}, 31'h7FFFFFFF})) begin
                r_fresh <= 32'h7FFFFFFF; r_fsat <= 1'b1;
            end else if (w_tot < -$signed({{(PRD_W-32){1'b0}}, 32'h80000000})) begin
                r_fresh <= 32'h80000000; r_fsat <= 1'b1;
            end else begin
                r_fresh <= w_tot[31:0]; r_fsat <= 1'b0;
            end
        end
    end

endmodule

/* rtl/matrix_vector_multiply_accumulate.sv */
// Scaled matrix-vector multiply-accumulate: b += c*A*x or b += c*A'*x.
// Input channel (push/full): mode, index, value. Loads of A, x, b give no
// result; out-of-range loads are dropped. A run request sweeps each row
// one multiply per cycle, then scales the row sum and adds it to b.
// Result channel (empty/pop): one result per b element, in order, last
// marked, saturated flags clipping. Elements come one at a time from the
// single multiplier in the sequential row sweep. A four-entry queue splits
// the request front from the back end so loads can queue while a run is
// in flight.
// Config channel (valid/ready): index 0 dim, 1 transpose, 2 scale. Write only
// while idle; ready is low while work is pending.
// Reset (synchronous, active low) clears b to zero, restores dim 16,
// transpose 0, scale 1.0. A stalled pop holds the sweep before the next
// element; nothing is lost.
module matrix_vector_multiply_accumulate #(
    parameter int MAX_DIM   = mvma_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = mvma_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [mvma_pkg::MODE_W-1:0]   i_mode,
    input  logic [mvma_pkg::INDEX_W-1:0]  i_index,
    input  logic [mvma_pkg::VAL_W-1:0]    i_value,
    output logic                          empty,
    input  logic                          pop,
    output logic [mvma_pkg::POS_W-1:0]    o_position,
    output logic [mvma_pkg::VAL_W-1:0]    o_result,
    output logic                          o_last,
    output logic                          o_saturated,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mvma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mvma_pkg::VAL_W-1:0]    i_cfg_data
);
    import mvma_pkg::*;

    logic [DIM_W-1:0] r_dim;
    logic             r_transpose;
    logic [VAL_W-1:0] r_scale;
    logic             w_req_valid, w_req_take, w_out_valid, w_busy;
    t_req             w_req;

    mvma_front #(.MAX_DIM(MAX_DIM)) u_front (
        .i_clk, .i_rst_n,
        .i_push(push), .o_full(full),
        .i_mode, .i_index, .i_value,
        .o_req_valid(w_req_valid), .o_req(w_req), .i_req_take(w_req_take)
    );

    mvma_back #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_dim(r_dim), .i_transpose(r_transpose), .i_scale(r_scale),
        .i_req_valid(w_req_valid), .i_req(w_req), .o_req_take(w_req_take),
        .o_out_valid(w_out_valid), .i_out_take(pop && w_out_valid),
        .o_position, .o_result, .o_last, .o_saturated, .o_busy(w_busy)
    );

    assign empty       = !w_out_valid;
    assign o_cfg_ready = !w_busy && !w_req_valid;

    // Hold configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim       <= DIM_W'(16);
            r_transpose <= 1'b0;
            r_scale     <= VAL_W'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DIM:       r_dim       <= i_cfg_data[DIM_W-1:0];
                CFG_TRANSPOSE: r_transpose <= i_cfg_data[0];
                CFG_SCALE:     r_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last) |-> (32'(o_position) < MAX_DIM)) else $error("last position");
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> empty) else $error("config while busy");

endmodule

/* tb/sv/mvma_checker.sv */
module mvma_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [mvma_pkg::MODE_W-1:0]    i_mode,
    input  logic [mvma_pkg::INDEX_W-1:0]   i_index,
    input  logic [mvma_pkg::VAL_W-1:0]     i_value,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [mvma_pkg::POS_W-1:0]     i_position,
    input  logic [mvma_pkg::VAL_W-1:0]     i_result,
    input  logic                           i_last,
    input  logic                           i_saturated,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [mvma_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mvma_pkg::VAL_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mvma_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] result;
        logic             last;
        logic             saturated;
    } t_b_update;

    // Shadow copy of the block state
    logic signed [31:0] a_mem [256];
    logic signed [31:0] x_mem [16];
    logic signed [31:0] b_mem [16];
    logic [DIM_W-1:0]   cur_dim;
    logic               cur_transpose;
    logic signed [31:0] cur_scale;
    t_b_update          updates_q [$];

    // Predict the b updates of one run request and queue them
    task automatic predict_gemv();
        int unsigned        n;
        logic signed [127:0] acc;
        logic signed [127:0] wide;
        logic signed [63:0]  prod;
        logic signed [31:0]  fresh [16];
        logic                clip [16];
        t_b_update           upd;
        n = (cur_dim == 0) ? 1 : (cur_dim > 16) ? 16 : cur_dim;
        for (int unsigned i = 0; i < n; i++) begin
            acc = '0;
            for (int unsigned j = 0; j < n; j++) begin
                prod = cur_transpose ? a_mem[j*n+i] * x_mem[j] : a_mem[i*n+j] * x_mem[j];
                acc  = acc + prod;
            end
            wide = (acc * 128'(cur_scale)) >>> (2 * FRAC_BITS_DEF);
            wide = wide + b_mem[i];
            clip[i] = 1'b1;
            if (wide > 128'sd2147483647)
                fresh[i] = 32'h7fff_ffff;
            else if (wide < -128'sd2147483648)
                fresh[i] = 32'h8000_0000;
            else begin
                fresh[i] = wide[31:0];
                clip[i]  = 1'b0;
            end
        end
        for (int unsigned i = 0; i < n; i++) begin
            b_mem[i]      = fresh[i];
            upd.position  = i[POS_W-1:0];
            upd.result    = fresh[i];
            upd.last      = (i + 1 == n);
            upd.saturated = clip[i];
            updates_q.push_back(upd);
        end
    endtask

    always @(posedge i_clk) begin
        t_b_update want;
        if (!i_rst_n) begin
            for (int k = 0; k < 16; k++) b_mem[k] = '0;
            cur_dim       = 5'd16;
            cur_transpose = 1'b0;
            cur_scale     = 32'sd65536;
            updates_q.delete();
            o_fail_count <= 0;
        end else begin
            // Track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_DIM:       cur_dim = i_cfg_data[DIM_W-1:0];
                    CFG_TRANSPOSE: cur_transpose = i_cfg_data[0];
                    CFG_SCALE:     cur_scale = i_cfg_data;
                    default: ;
                endcase
            end
            // Track accepted requests
            if (i_push && !i_full) begin
                case (t_mode'(i_mode))
                    MODE_LOAD_A: a_mem[i_index] = i_value;
                    MODE_LOAD_X: if (i_index < 16) x_mem[i_index[3:0]] = i_value;
                    MODE_LOAD_B: if (i_index < 16) b_mem[i_index[3:0]] = i_value;
                    default:     predict_gemv();
                endcase
            end
            // Compare each popped result with the oldest prediction
            if (i_pop && !i_empty) begin
                if (updates_q.size() == 0) begin
                    $display("%0t: unexpected result pos=%0d result=%h last=%b sat=%b",
                             $time, i_position, i_result, i_last, i_saturated);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = updates_q.pop_front();
                    if ({i_position, i_result, i_last, i_saturated} !== want) begin
                        $display("%0t: mismatch expected pos=%0d result=%h last=%b sat=%b",
                                 $time, want.position, want.result, want.last,
                                 want.saturated);
                        $display("%0t:          actual   pos=%0d result=%h last=%b sat=%b",
                                 $time, i_position, i_result, i_last, i_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= updates_q.size();
    end

endmodule

/* tb/sv/tb_matrix_vector_multiply_accumulate.sv */
module tb_matrix_vector_multiply_accumulate;
    timeunit 1ns;
    timeprecision 1ps;
    import mvma_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [MODE_W-1:0]    mode;
    logic [INDEX_W-1:0]   index;
    logic [VAL_W-1:0]     value;
    logic                 empty;
    logic                 pop;
    logic [POS_W-1:0]     position;
    logic [VAL_W-1:0]     result;
    logic                 last;
    logic                 saturated;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;

    int unsigned idle_pct;
    int unsigned stall_pct;
    logic        hold_go;
    int          hold_left;
    logic        a_written [256];
    logic        x_written [16];
    int unsigned eff_dim;

    matrix_vector_multiply_accumulate DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .push(push), .full(full),
        .i_mode(mode), .i_index(index), .i_value(value),
        .empty(empty), .pop(pop),
        .o_position(position), .o_result(result), .o_last(last),
        .o_saturated(saturated),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    mvma_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_push(push), .i_full(full),
        .i_mode(mode), .i_index(index), .i_value(value),
        .i_empty(empty), .i_pop(pop),
        .i_position(position), .i_result(result), .i_last(last),
        .i_saturated(saturated),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Drain results with random stalls; hold off once for a long stretch
    always @(posedge clk) begin
        if (!rst_n) begin
            pop       <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_go && hold_left > 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
        endcase
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(t_mode m, logic [7:0] idx, logic [31:0] val);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        mode  <= m;
        index <= idx;
        value <= val;
        if (m == MODE_LOAD_A) a_written[idx] = 1'b1;
        if (m == MODE_LOAD_X && idx < 16) x_written[idx] = 1'b1;
        do @(posedge clk); while (full);
    endtask

    // Make sure every A and x entry the run will read holds a value, then request the run
    task automatic run_gemv();
        for (int k = 0; k < eff_dim * eff_dim; k++)
            if (!a_written[k]) send_request(MODE_LOAD_A, k[7:0], pick_value());
        for (int k = 0; k < eff_dim; k++)
            if (!x_written[k]) send_request(MODE_LOAD_X, k[7:0], pick_value());
        send_request(MODE_RUN, 8'($urandom()), $urandom());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DIM)
            eff_dim = (data[4:0] == 0) ? 1 : (data[4:0] > 16) ? 16 : data[4:0];
    endtask

    // One well-formed load sequence with random content, then a run
    task automatic random_sequence();
        int unsigned cnt;
        cnt = $urandom_range(eff_dim * 2);
        repeat (cnt) send_request(MODE_LOAD_A, 8'($urandom_range(eff_dim * eff_dim - 1)),
                                  pick_value());
        repeat ($urandom_range(eff_dim)) send_request(MODE_LOAD_X,
                                                      8'($urandom_range(eff_dim - 1)),
                                                      pick_value());
        repeat ($urandom_range(2)) send_request(MODE_LOAD_B, 8'($urandom_range(15)),
                                                pick_value());
        // Sprinkle dropped loads and stray matrix writes
        if ($urandom_range(9) == 0)
            send_request(t_mode'($urandom_range(1, 2)), 8'($urandom_range(16, 255)),
                         $urandom());
        if ($urandom_range(9) == 0)
            send_request(MODE_LOAD_A, 8'($urandom()), $urandom());
        run_gemv();
    endtask

    initial begin
        #20ms;
        $display("FAIL matrix_vector_multiply_accumulate");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        push      = 1'b0;
        mode      = MODE_LOAD_A;
        index     = '0;
        value     = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DIM;
        cfg_data  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b0;
        eff_dim   = 16;
        for (int k = 0; k < 256; k++) a_written[k] = 1'b0;
        for (int k = 0; k < 16; k++) x_written[k] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes at dim 2, saturation both ways, dropped loads
        write_reg(CFG_DIM, 32'd2);
        send_request(MODE_LOAD_A, 8'd0, 32'h7fff_ffff);
        send_request(MODE_LOAD_A, 8'd1, 32'h8000_0000);
        send_request(MODE_LOAD_A, 8'd2, 32'h0000_0000);
        send_request(MODE_LOAD_A, 8'd3, 32'hffff_ffff);
        send_request(MODE_LOAD_X, 8'd0, 32'h7fff_ffff);
        send_request(MODE_LOAD_X, 8'd1, 32'h8000_0000);
        send_request(MODE_LOAD_B, 8'd0, 32'h7fff_ffff);
        send_request(MODE_LOAD_B, 8'd1, 32'h8000_0000);
        send_request(MODE_LOAD_X, 8'd16, 32'h1234_5678);
        send_request(MODE_LOAD_B, 8'd255, 32'hdead_beef);
        send_request(MODE_LOAD_A, 8'd255, 32'h0001_0000);
        run_gemv();
        run_gemv();
        write_reg(CFG_TRANSPOSE, 32'd1);
        write_reg(CFG_SCALE, 32'h8000_0000);
        run_gemv();
        write_reg(CFG_UNUSED, 32'hffff_ffff);
        write_reg(CFG_DIM, 32'd0);
        send_request(MODE_LOAD_B, 8'd0, 32'h0000_0000);
        run_gemv();
        write_reg(CFG_SCALE, 32'h7fff_ffff);
        write_reg(CFG_DIM, 32'd31);
        run_gemv();

        // Random phases across settings and idling profiles
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            write_reg(CFG_DIM, (phase == 5) ? 32'd16 : 32'($urandom_range(1, 6)));
            write_reg(CFG_TRANSPOSE, $urandom_range(1));
            write_reg(CFG_SCALE, ($urandom_range(2) == 0) ? $urandom()
                                 : 32'($signed($urandom_range(4 * 65536)) - 2 * 65536));
            if (phase == 2) hold_go <= 1'b1;
            repeat ((phase == 5) ? 1 : 3) random_sequence();
        end
        // Two more short runs at dim 3 with random output stalls
        idle_pct = 0;
        stall_pct = 20;
        write_reg(CFG_DIM, 32'd3);
        repeat (2) random_sequence();

        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASS matrix_vector_multiply_accumulate");
        else
            $display("FAIL matrix_vector_multiply_accumulate");
        $finish;
    end

endmodule

/* files.f */
rtl/mvma_pkg.sv
rtl/mvma_front.sv
rtl/mvma_back.sv
rtl/matrix_vector_multiply_accumulate.sv
tb/sv/mvma_checker.sv
tb/sv/tb_matrix_vector_multiply_accumulate.sv
